// File: src/dp_pkg.sv
// dp_pkg: shared widths, constants, register codes and word types for the
// depth-to-point back-projection pipeline. No dependencies.
`default_nettype none

package dp_pkg;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 11;
    localparam int DEPTH_W    = 16;
    localparam int COEF_W     = 32;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // frame bounds
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int BOUND_W    = 14;

    // datapath widths
    localparam int PROD_W   = 44;
    localparam int LIN_W    = 45;
    localparam int LO_SPLIT = 23;
    localparam int LO_W     = LO_SPLIT + DEPTH_W;
    localparam int HI_W     = LIN_W - LO_SPLIT + DEPTH_W + 1;
    localparam int SUM_W    = 62;
    localparam int FRAC_DROP = 12;
    localparam int T_W      = SUM_W - FRAC_DROP;
    localparam int N_W      = 39;
    localparam int NL_W     = 20;
    localparam int NH_W     = N_W - NL_W;
    localparam int RECIP_W  = 33;
    localparam int PL_W     = NL_W + RECIP_W;
    localparam int PH_W     = NH_W + RECIP_W;
    localparam int ACC_W    = 72;
    localparam int RES_LSB  = 39;
    localparam int CORR_W   = 9;

    // floor division by 1000 * 2^12, done as >>12, >>3, then /125
    localparam logic signed [T_W-1:0] SAT_HI = 50'sd2147483648000;
    localparam logic signed [T_W-1:0] SAT_LO = -50'sd2147483648000;
    localparam logic [N_W-1:0]        DIV_OFFSET = 39'd268435456000;
    localparam logic [RECIP_W-1:0]    RECIP_125  = 33'd4398046511;
    localparam logic [CORR_W-1:0]     DIV_CORR   = 9'd125;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    localparam logic signed [COORD_W-1:0] MIN_Z_RESET = 32'sd26214;
    localparam logic signed [COORD_W-1:0] MAX_Z_RESET = 32'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KINV_01 = 3'd0,
        REG_KINV_23 = 3'd1,
        REG_KINV_45 = 3'd2,
        REG_KINV_67 = 3'd3,
        REG_KINV_8  = 3'd4,
        REG_MIN_Z   = 3'd5,
        REG_MAX_Z   = 3'd6
    } cfg_reg_t;

    typedef logic [8:0][COEF_W-1:0] kinv_t;

    typedef struct packed {
        logic [2:0][LIN_W-1:0] lin;
        logic [DEPTH_W-1:0]    depth;
        logic                  in_frame;
    } lin_word_t;

    typedef struct packed {
        logic [2:0][T_W-1:0] t;
        logic                in_frame;
    } scl_word_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;
        logic                    in_frame;
    } pt_word_t;

endpackage

`default_nettype wire

// File: src/dp_if.sv
// dp_if: valid/ready channel interfaces for pixel input, point output and
// configuration writes. Depends on dp_pkg.
`default_nettype none

interface dp_pix_if
    import dp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_mm;

    modport source (output valid, col, row, depth_mm, input ready);
    modport sink   (input valid, col, row, depth_mm, output ready);
endinterface

interface dp_pt_if
    import dp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_m;
    logic [COORD_W-1:0] y_m;
    logic [COORD_W-1:0] z_m;
    logic               in_range;

    modport source (output valid, x_m, y_m, z_m, in_range, input ready);
    modport sink   (input valid, x_m, y_m, z_m, in_range, output ready);
endinterface

interface dp_cfg_if
    import dp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/dp_lin.sv
// dp_lin: two pipeline stages forming u*k[3r] + v*k[3r+1] + k[3r+2] per row.
// Depends on dp_pkg.
`default_nettype none

module dp_lin
    import dp_pkg::*;
#(
    parameter int FRAME_WIDTH  = MAX_WIDTH,
    parameter int FRAME_HEIGHT = MAX_HEIGHT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kinv_t              kinv,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [COL_W-1:0]   col,
    input  wire logic [ROW_W-1:0]   row,
    input  wire logic [DEPTH_W-1:0] depth_mm,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lin_word_t               out_word
);
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [LIN_W-1:0]  lin_t;

    localparam logic [BOUND_W-1:0] WIDTH_BOUND  = BOUND_W'(FRAME_WIDTH);
    localparam logic [BOUND_W-1:0] HEIGHT_BOUND = BOUND_W'(FRAME_HEIGHT);

    logic               a_valid_reg, a_valid_next, a_ready;
    logic [2:0][PROD_W-1:0] pu_reg, pu_next, pv_reg, pv_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic               in_frame_reg, in_frame_next;

    logic               b_valid_reg, b_valid_next, b_ready;
    lin_word_t          word_reg, word_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // stage a: per-row products
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            pu_next[r] = prod_t'($signed({1'b0, col})) * prod_t'($signed(kinv[3*r]));
            pv_next[r] = prod_t'($signed({1'b0, row})) * prod_t'($signed(kinv[3*r+1]));
        end
        in_frame_next = ({3'b000, col} < WIDTH_BOUND) && ({3'b000, row} < HEIGHT_BOUND);
    end

    // stage b: row sums
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            word_next.lin[r] = lin_t'($signed(pu_reg[r])) + lin_t'($signed(pv_reg[r]))
                             + lin_t'($signed(kinv[3*r+2]));
        end
        word_next.depth    = depth_reg;
        word_next.in_frame = in_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            pu_reg       <= pu_next;
            pv_reg       <= pv_next;
            depth_reg    <= depth_mm;
            in_frame_reg <= in_frame_next;
        end
        if (b_ready && a_valid_reg)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: src/dp_scale.sv
// dp_scale: two pipeline stages multiplying each row sum by depth and
// dropping 12 fraction bits with floor. Depends on dp_pkg.
`default_nettype none

module dp_scale
    import dp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire lin_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output scl_word_t      out_word
);
    typedef logic signed [HI_W-1:0]  hi_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    logic                   c_valid_reg, c_valid_next, c_ready;
    logic [2:0][LO_W-1:0]   lo_reg, lo_next;
    logic [2:0][HI_W-1:0]   hi_reg, hi_next;
    logic                   in_frame_reg;

    logic                   d_valid_reg, d_valid_next, d_ready;
    scl_word_t              word_reg, word_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    assign c_valid_next = c_ready ? in_valid : c_valid_reg;
    assign d_valid_next = d_ready ? c_valid_reg : d_valid_reg;

    // stage c: split depth product into low unsigned and high signed parts
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            lo_next[r] = LO_W'(in_word.depth) * LO_W'(in_word.lin[r][LO_SPLIT-1:0]);
            hi_next[r] = hi_t'($signed({1'b0, in_word.depth}))
                       * hi_t'($signed(in_word.lin[r][LIN_W-1:LO_SPLIT]));
        end
    end

    // stage d: recombine and floor-shift
    always_comb
    begin
        sum_t s;
        s = '0;
        for (int r = 0; r < 3; r++)
        begin
            s = (sum_t'($signed(hi_reg[r])) <<< LO_SPLIT)
              + sum_t'({{(SUM_W-LO_W){1'b0}}, lo_reg[r]});
            word_next.t[r] = s[SUM_W-1:FRAC_DROP];
        end
        word_next.in_frame = in_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            in_frame_reg <= in_word.in_frame;
        end
        if (d_ready && c_valid_reg)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: src/dp_div.sv
// dp_div: four pipeline stages giving saturated floor(t/1000) per row by
// offset, reciprocal multiply and one correction step. Depends on dp_pkg.
`default_nettype none

module dp_div
    import dp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire scl_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pt_word_t       out_word
);
    // stage e
    logic                    e_valid_reg, e_valid_next, e_ready;
    logic [2:0][N_W-1:0]     n_reg, n_next;
    logic [2:0]              sat_hi_e_reg, sat_hi_e_next, sat_lo_e_reg, sat_lo_e_next;
    logic                    in_frame_e_reg;
    // stage f
    logic                    f_valid_reg, f_valid_next, f_ready;
    logic [2:0][PL_W-1:0]    pl_reg, pl_next;
    logic [2:0][PH_W-1:0]    ph_reg, ph_next;
    logic [2:0][CORR_W-1:0]  n_f_reg;
    logic [2:0]              sat_hi_f_reg, sat_lo_f_reg;
    logic                    in_frame_f_reg;
    // stage g
    logic                    g_valid_reg, g_valid_next, g_ready;
    logic [2:0][COORD_W-1:0] q_reg, q_next;
    logic [2:0][CORR_W-1:0]  n_g_reg;
    logic [2:0]              sat_hi_g_reg, sat_lo_g_reg;
    logic                    in_frame_g_reg;
    // stage h
    logic                    h_valid_reg, h_valid_next, h_ready;
    pt_word_t                word_reg, word_next;

    assign h_ready  = !h_valid_reg || out_ready;
    assign g_ready  = !g_valid_reg || h_ready;
    assign f_ready  = !f_valid_reg || g_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    assign e_valid_next = e_ready ? in_valid : e_valid_reg;
    assign f_valid_next = f_ready ? e_valid_reg : f_valid_reg;
    assign g_valid_next = g_ready ? f_valid_reg : g_valid_reg;
    assign h_valid_next = h_ready ? g_valid_reg : h_valid_reg;

    // stage e: saturation test and offset to a non-negative dividend
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sat_hi_e_next[r] = $signed(in_word.t[r]) >= SAT_HI;
            sat_lo_e_next[r] = $signed(in_word.t[r]) < SAT_LO;
            n_next[r]        = in_word.t[r][N_W+2:3] + DIV_OFFSET;
        end
    end

    // stage f: partial products against the reciprocal of 125
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            pl_next[r] = PL_W'(n_reg[r][NL_W-1:0]) * PL_W'(RECIP_125);
            ph_next[r] = PH_W'(n_reg[r][N_W-1:NL_W]) * PH_W'(RECIP_125);
        end
    end

    // stage g: estimated quotient, low by at most one
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        acc = '0;
        for (int r = 0; r < 3; r++)
        begin
            acc       = (ACC_W'(ph_reg[r]) << NL_W) + ACC_W'(pl_reg[r]);
            q_next[r] = acc[RES_LSB+COORD_W-1:RES_LSB];
        end
    end

    // stage h: correction, offset removal, saturation
    always_comb
    begin
        logic [CORR_W-1:0]  rem;
        logic [COORD_W-1:0] q;
        rem = '0;
        q   = '0;
        for (int r = 0; r < 3; r++)
        begin
            rem = n_g_reg[r] - CORR_W'(q_reg[r][CORR_W-1:0] * DIV_CORR);
            q   = q_reg[r] + COORD_W'(rem >= DIV_CORR);
            if (sat_hi_g_reg[r])
            begin
                word_next.p[r] = COORD_MAX;
            end
            else if (sat_lo_g_reg[r])
            begin
                word_next.p[r] = COORD_MIN;
            end
            else
            begin
                word_next.p[r] = {~q[COORD_W-1], q[COORD_W-2:0]};
            end
        end
        word_next.in_frame = in_frame_g_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            f_valid_reg <= f_valid_next;
            g_valid_reg <= g_valid_next;
            h_valid_reg <= h_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            n_reg          <= n_next;
            sat_hi_e_reg   <= sat_hi_e_next;
            sat_lo_e_reg   <= sat_lo_e_next;
            in_frame_e_reg <= in_word.in_frame;
        end
        if (f_ready && e_valid_reg)
        begin
            pl_reg         <= pl_next;
            ph_reg         <= ph_next;
            for (int r = 0; r < 3; r++)
            begin
                n_f_reg[r] <= n_reg[r][CORR_W-1:0];
            end
            sat_hi_f_reg   <= sat_hi_e_reg;
            sat_lo_f_reg   <= sat_lo_e_reg;
            in_frame_f_reg <= in_frame_e_reg;
        end
        if (g_ready && f_valid_reg)
        begin
            q_reg          <= q_next;
            n_g_reg        <= n_f_reg;
            sat_hi_g_reg   <= sat_hi_f_reg;
            sat_lo_g_reg   <= sat_lo_f_reg;
            in_frame_g_reg <= in_frame_f_reg;
        end
        if (h_ready && g_valid_reg)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = h_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: src/dp_out.sv
// dp_out: output register stage applying the z window and frame test.
// Depends on dp_pkg.
`default_nettype none

module dp_out
    import dp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic signed [COORD_W-1:0] min_z,
    input  wire logic signed [COORD_W-1:0] max_z,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pt_word_t                  in_word,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COORD_W-1:0]             x_m,
    output logic [COORD_W-1:0]             y_m,
    output logic [COORD_W-1:0]             z_m,
    output logic                           in_range
);
    logic               valid_reg, valid_next;
    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               ok_reg, ok_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        ok_next = in_word.in_frame
               && ($signed(in_word.p[2]) > min_z)
               && ($signed(in_word.p[2]) < max_z);
        x_next  = ok_next ? in_word.p[0] : '0;
        y_next  = ok_next ? in_word.p[1] : '0;
        z_next  = ok_next ? in_word.p[2] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            ok_reg <= ok_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_m       = x_reg;
    assign y_m       = y_reg;
    assign z_m       = z_reg;
    assign in_range  = ok_reg;

endmodule

`default_nettype wire

// File: src/depth_to_point_back_projection_top.sv
// Depth pixel to 3-D point back-projection, top level with configuration registers.
// Depends on dp_pkg, dp_if, dp_lin, dp_scale, dp_div and dp_out.
//
// Takes one depth pixel (col, row, depth_mm) per clock and returns one point per
// pixel, in order: depth*(K^-1 * (u, v, 1)) in Q16.16 metres, floored and saturated,
// zeroed with in_range low when z is outside (min_z, max_z) or the pixel lies
// outside the frame set by FRAME_WIDTH and FRAME_HEIGHT. Throughput is one pixel
// per cycle; the path from input accept to output accept runs through 9 register
// stages (two for the row sums, two for the depth product, four for the divide
// by 1000 via reciprocal multiply, one output register). Each stage holds its
// word under backpressure and bubbles close up, so input is taken while results
// wait. Configuration writes are always accepted and must be made while the
// pipeline is empty.
`default_nettype none

module depth_to_point_back_projection_top
    import dp_pkg::*;
#(
    parameter int FRAME_WIDTH  = MAX_WIDTH,
    parameter int FRAME_HEIGHT = MAX_HEIGHT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dp_cfg_if.sink     cfg,
    dp_pix_if.sink     pixel,
    dp_pt_if.source    point
);
    kinv_t                      kinv_reg, kinv_next;
    logic signed [COORD_W-1:0]  min_z_reg, min_z_next, max_z_reg, max_z_next;

    logic      lin_valid, lin_ready;
    lin_word_t lin_word;
    logic      scl_valid, scl_ready;
    scl_word_t scl_word;
    logic      div_valid, div_ready;
    pt_word_t  div_word;

    assign cfg.ready = 1'b1;

    // register writes
    always_comb
    begin
        kinv_next  = kinv_reg;
        min_z_next = min_z_reg;
        max_z_next = max_z_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_KINV_01:
                begin
                    kinv_next[0] = cfg.data[31:0];
                    kinv_next[1] = cfg.data[63:32];
                end
                REG_KINV_23:
                begin
                    kinv_next[2] = cfg.data[31:0];
                    kinv_next[3] = cfg.data[63:32];
                end
                REG_KINV_45:
                begin
                    kinv_next[4] = cfg.data[31:0];
                    kinv_next[5] = cfg.data[63:32];
                end
                REG_KINV_67:
                begin
                    kinv_next[6] = cfg.data[31:0];
                    kinv_next[7] = cfg.data[63:32];
                end
                REG_KINV_8:  kinv_next[8] = cfg.data[31:0];
                REG_MIN_Z:   min_z_next   = $signed(cfg.data[31:0]);
                REG_MAX_Z:   max_z_next   = $signed(cfg.data[31:0]);
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kinv_reg  <= '0;
            min_z_reg <= MIN_Z_RESET;
            max_z_reg <= MAX_Z_RESET;
        end
        else
        begin
            kinv_reg  <= kinv_next;
            min_z_reg <= min_z_next;
            max_z_reg <= max_z_next;
        end
    end

    dp_lin #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_lin (
        .clk       (clk),
        .rst_n     (rst_n),
        .kinv      (kinv_reg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .col       (pixel.col),
        .row       (pixel.row),
        .depth_mm  (pixel.depth_mm),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .out_word  (lin_word)
    );

    dp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .in_word   (lin_word),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_word  (scl_word)
    );

    dp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_word   (scl_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    dp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_z     (min_z_reg),
        .max_z     (max_z_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_word   (div_word),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .x_m       (point.x_m),
        .y_m       (point.y_m),
        .z_m       (point.z_m),
        .in_range  (point.in_range)
    );

endmodule

`default_nettype wire
